FILE: src/ble_pkg.sv
// Package for the bounded list engine: sizes, operation and status codes,
// and the control word that the sequencer hands to every list cell.
// No dependencies.
package ble_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND   = 3'd0,
    MODE_DISPLAY  = 3'd1,
    MODE_DEL_HEAD = 3'd2,
    MODE_DEL_TAIL = 3'd3,
    MODE_DEL_POS  = 3'd4
  } ble_mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 3'd0,
    STAT_EMPTY = 3'd1,
    STAT_RANGE = 3'd2,
    STAT_FULL  = 3'd3,
    STAT_WORD  = 3'd4
  } ble_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } ble_state_e;

  // load:   the cell at sel_idx takes the appended word
  // shift:  cells at sel_idx and above take their upper neighbor
  // rotate: all cells take their upper neighbor, the cell at sel_idx takes the head
  typedef struct packed {
    logic             load;
    logic             shift;
    logic             rotate;
    logic [IDX_W-1:0] sel_idx;
  } ble_cell_ctrl_t;

endpackage

FILE: src/ble_cell.sv
// One storage cell of the list chain: holds one word and moves it
// toward the head on shift or rotate. Depends on ble_pkg.
module ble_cell (
  input  logic                          clk_i,
  input  logic [ble_pkg::IDX_W-1:0]     idx_i,
  input  ble_pkg::ble_cell_ctrl_t       ctrl_i,
  input  logic signed [ble_pkg::WORD_W-1:0] value_i,
  input  logic signed [ble_pkg::WORD_W-1:0] head_i,
  input  logic signed [ble_pkg::WORD_W-1:0] next_i,
  output logic signed [ble_pkg::WORD_W-1:0] data_o
);
  import ble_pkg::*;

  logic signed [WORD_W-1:0] data_q;
  logic signed [WORD_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load && (idx_i == ctrl_i.sel_idx)) begin
      data_d = value_i;
    end else if (ctrl_i.shift && (idx_i >= ctrl_i.sel_idx)) begin
      data_d = next_i;
    end else if (ctrl_i.rotate) begin
      data_d = (idx_i == ctrl_i.sel_idx) ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

FILE: src/bounded_list_engine.sv
// Top level of the bounded list engine: sequencer, result register and the
// chain of list cells. Depends on ble_pkg and ble_cell.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation: mode,
//   value (append only) and position (delete at position only). Output
//   channel (out_valid_o / out_stall_i) carries result transfers: status,
//   word, last and length. A transfer happens when valid is high and stall
//   is low.
//   Every operation but display gives one result, registered the cycle after
//   the input transfer. Display of N words streams N results, one per cycle
//   while the receiver does not stall, head first, with last on the final one;
//   the chain rotates one place per result and is back in order after the last.
//   Display of an empty list gives one empty status.
//   Throughput: one operation per cycle for append and deletes while the receiver
//   does not stall; display holds the input until its last word is loaded. Each
//   append is one load, each delete at most one shift, each word one rotation.
//   When the receiver stalls, the result register holds and the input
//   stalls; the chain stays put until the result is taken.
//   Reset empties the list at once (length zero); no clearing pass. Cells
//   are not reset; only cells below the length are ever read.
module bounded_list_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ble_pkg::MODE_W-1:0]         in_mode_i,
  input  logic signed [ble_pkg::WORD_W-1:0]  in_value_i,
  input  logic [ble_pkg::POS_W-1:0]          in_position_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ble_pkg::STAT_W-1:0]         out_status_o,
  output logic signed [ble_pkg::WORD_W-1:0]  out_word_o,
  output logic                               out_last_o,
  output logic [ble_pkg::LEN_W-1:0]          out_length_o
);
  import ble_pkg::*;

  // Control state
  ble_state_e        state_q, state_d;
  logic [LEN_W-1:0]  occ_q, occ_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  // Result register (payload, no reset)
  ble_status_e              status_q, status_d;
  logic signed [WORD_W-1:0] word_q, word_d;
  logic                     last_q, last_d;
  logic [LEN_W-1:0]         length_q;

  logic              out_free;
  logic              in_acc;
  logic              load_out;
  ble_cell_ctrl_t    ctrl;
  logic [IDX_W-1:0]  tail_idx;

  logic signed [WORD_W-1:0] cell_data [CAPACITY];
  logic signed [WORD_W-1:0] cell_next [CAPACITY];

  // The result register is free when empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == ST_DISP) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tail_idx   = IDX_W'(occ_q - LEN_W'(1));

  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    load_out    = 1'b0;
    status_d    = STAT_DONE;
    word_d      = '0;
    last_d      = 1'b1;
    ctrl        = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          case (in_mode_i)
            MODE_APPEND: begin
              if (occ_q >= LEN_W'(CAPACITY)) begin
                status_d = STAT_FULL;
              end else begin
                ctrl.load    = 1'b1;
                ctrl.sel_idx = IDX_W'(occ_q);
                occ_d        = occ_q + LEN_W'(1);
              end
            end
            MODE_DISPLAY: begin
              if (occ_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                // Emit the head and rotate it to the tail.
                ctrl.rotate  = 1'b1;
                ctrl.sel_idx = tail_idx;
                status_d     = STAT_WORD;
                word_d       = cell_data[0];
                last_d       = (occ_q == LEN_W'(1));
                cnt_d        = LEN_W'(1);
                if (occ_q != LEN_W'(1)) begin
                  state_d = ST_DISP;
                end
              end
            end
            MODE_DEL_HEAD: begin
              if (occ_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                ctrl.shift   = 1'b1;
                ctrl.sel_idx = '0;
                occ_d        = occ_q - LEN_W'(1);
              end
            end
            MODE_DEL_TAIL: begin
              if (occ_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                // Drop the tail by shortening the list; cells hold.
                occ_d = occ_q - LEN_W'(1);
              end
            end
            MODE_DEL_POS: begin
              if (occ_q == '0) begin
                status_d = STAT_EMPTY;
              end else if ((in_position_i == '0) ||
                           (in_position_i > POS_W'(occ_q))) begin
                status_d = STAT_RANGE;
              end else begin
                ctrl.shift   = 1'b1;
                ctrl.sel_idx = IDX_W'(in_position_i - POS_W'(1));
                occ_d        = occ_q - LEN_W'(1);
              end
            end
            default: begin
              status_d = STAT_DONE;
            end
          endcase
        end
      end
      ST_DISP: begin
        if (out_free) begin
          load_out     = 1'b1;
          ctrl.rotate  = 1'b1;
          ctrl.sel_idx = tail_idx;
          status_d     = STAT_WORD;
          word_d       = cell_data[0];
          last_d       = (cnt_q == (occ_q - LEN_W'(1)));
          cnt_d        = cnt_q + LEN_W'(1);
          if (last_d) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = load_out || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= status_d;
      word_q   <= word_d;
      last_q   <= last_d;
      length_q <= occ_d;
    end
  end

  // Cell chain: each cell's upper neighbor feeds it; the top cell sees itself.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_top
      assign cell_next[i] = cell_data[i];
    end else begin : g_mid
      assign cell_next[i] = cell_data[i+1];
    end

    ble_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctrl_i  (ctrl),
      .value_i (in_value_i),
      .head_i  (cell_data[0]),
      .next_i  (cell_next[i]),
      .data_o  (cell_data[i])
    );
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = status_q;
  assign out_word_o   = word_q;
  assign out_last_o   = last_q;
  assign out_length_o = length_q;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= LEN_W'(CAPACITY))
    else $error("list length above capacity");

  a_notlast_is_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_last_o) |-> (out_status_o == STAT_WORD))
    else $error("non-final result that is not a display word");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == STAT_FULL)) |-> (out_length_o == LEN_W'(CAPACITY)))
    else $error("full status with list not full");

  a_empty_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_status_o == STAT_EMPTY)) |-> (out_length_o == '0))
    else $error("empty status with nonzero length");

  a_disp_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DISP && out_free && last_d) |=> (state_q == ST_IDLE && out_last_o))
    else $error("display did not close with last");
`endif

endmodule

FILE: dv/tb_bounded_list_engine.sv
// Self-checking testbench for bounded_list_engine: a directed table, then random
// operation sequences, checked against typed-in results or a behavioral list tracker.
// Depends on ble_pkg and the bounded_list_engine RTL.
module tb_bounded_list_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ble_pkg::*;

  // Mode codes beyond the defined operations: the block treats them as no-ops.
  localparam logic [MODE_W-1:0] MODE_UNUSED5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED7 = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  localparam int unsigned TOTAL_OPS    = 220;
  localparam int unsigned NUM_DIRECTED = 25;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [WORD_W-1:0] word;
    logic                     last;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  // One row of the directed table. Rows with known_result set carry the single
  // result typed in; the rest are checked against the list tracker.
  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         position;
    bit                       known_result;
    ble_status_e              status;
    logic [LEN_W-1:0]         length;
  } op_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [MODE_W-1:0]        in_mode_i = '0;
  logic signed [WORD_W-1:0] in_value_i = '0;
  logic [POS_W-1:0]         in_position_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [STAT_W-1:0]        out_status_o;
  logic signed [WORD_W-1:0] out_word_o;
  logic                     out_last_o;
  logic [LEN_W-1:0]         out_length_o;

  bounded_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_mode_i     (in_mode_i),
    .in_value_i    (in_value_i),
    .in_position_i (in_position_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_status_o  (out_status_o),
    .out_word_o    (out_word_o),
    .out_last_o    (out_last_o),
    .out_length_o  (out_length_o)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // List tracker: a copy of the stored words, head first, and their count.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int unsigned              list_len = 0;
  list_result_t             op_results [$];      // results of the latest operation
  list_result_t             pending_results [$]; // results still owed by the block

  bit          idle_on = 1'b1;
  int unsigned ops_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  function automatic void add_result(logic [STAT_W-1:0] st, logic signed [WORD_W-1:0] w,
                                     logic lst);
    list_result_t r;
    r.status = st;
    r.word   = w;
    r.last   = lst;
    r.length = list_len[LEN_W-1:0];
    op_results.push_back(r);
  endfunction

  // Close the gap at idx: every word behind it moves up one place.
  function automatic void remove_word(int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_len; i++) list_words[i] = list_words[i + 1];
    list_len--;
  endfunction

  // Apply one operation to the tracked list and fill op_results with what it
  // gives. Length in every result is the count after the operation.
  function automatic void apply_list_op(logic [MODE_W-1:0] mode,
                                        logic signed [WORD_W-1:0] value,
                                        logic [POS_W-1:0] position);
    op_results.delete();
    case (mode)
      MODE_APPEND: begin
        if (list_len >= CAPACITY) begin
          add_result(STAT_FULL, '0, 1'b1);
        end else begin
          list_words[list_len] = value;
          list_len++;
          add_result(STAT_DONE, '0, 1'b1);
        end
      end
      MODE_DISPLAY: begin
        if (list_len == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_len; i++)
            add_result(STAT_WORD, list_words[i], i + 1 == list_len);
        end
      end
      MODE_DEL_HEAD, MODE_DEL_TAIL: begin
        if (list_len == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          remove_word(mode == MODE_DEL_HEAD ? 0 : list_len - 1);
          add_result(STAT_DONE, '0, 1'b1);
        end
      end
      MODE_DEL_POS: begin
        // An empty list wins over the position check.
        if (list_len == 0) begin
          add_result(STAT_EMPTY, '0, 1'b1);
        end else if (position == 0 || position > list_len) begin
          add_result(STAT_RANGE, '0, 1'b1);
        end else begin
          remove_word(position - 1);
          add_result(STAT_DONE, '0, 1'b1);
        end
      end
      default: begin
        add_result(STAT_DONE, '0, 1'b1);
      end
    endcase
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias random words toward the signed extremes and the all-zero and all-one words.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: hold valid and payload until the transfer, then log what the
  // block owes for it.
  // ---------------------------------------------------------------------------
  task automatic issue_op(logic [MODE_W-1:0] mode, logic signed [WORD_W-1:0] value,
                          logic [POS_W-1:0] position, bit known_result = 1'b0,
                          ble_status_e status = STAT_DONE, logic [LEN_W-1:0] length = '0);
    int unsigned  gap;
    list_result_t r;
    gap = pick_gap(idle_on);
    @(negedge clk_i);
    if (gap > 0) begin
      // Drop valid for the gap, then raise it with the new payload.
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    in_mode_i     <= mode;
    in_value_i    <= value;
    in_position_i <= position;
    do @(posedge clk_i); while (in_stall_o);
    apply_list_op(mode, value, position);
    if (known_result) begin
      r.status = status;
      r.word   = '0;
      r.last   = 1'b1;
      r.length = length;
      pending_results.push_back(r);
    end else begin
      foreach (op_results[i]) pending_results.push_back(op_results[i]);
    end
    ops_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, held for runs of random length.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      stall_left = pick_gap(idle_on);
      out_stall_i <= (stall_left > 0);
      if (stall_left > 0) stall_left = stall_left - 1;
    end
  end

  // Compare every result transfer against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result: status=%0d word=%0d last=%0b length=%0d",
                   $realtime, out_status_o, out_word_o, out_last_o, out_length_o);
      end else begin
        want = pending_results.pop_front();
        if (out_status_o !== want.status || out_word_o !== want.word ||
            out_last_o !== want.last || out_length_o !== want.length) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result differs: expected %0d/%0d/%0b/%0d got %0d/%0d/%0b/%0d",
                     $realtime, want.status, want.word, want.last, want.length,
                     out_status_o, out_word_o, out_last_o, out_length_o);
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  op_row_t directed_ops [NUM_DIRECTED];

  initial begin
    int unsigned burst;
    int unsigned pos_hi;

    // Status/length only where it is obvious; display rows with words go to the tracker.
    directed_ops = '{
      // empty list: display and every delete report empty, an unused mode is a no-op
      '{MODE_DISPLAY,  32'sd0,  8'd0,   1'b1, STAT_EMPTY, 5'd0},
      '{MODE_DEL_HEAD, 32'sd0,  8'd0,   1'b1, STAT_EMPTY, 5'd0},
      '{MODE_DEL_TAIL, 32'sd0,  8'd0,   1'b1, STAT_EMPTY, 5'd0},
      '{MODE_DEL_POS,  32'sd0,  8'd0,   1'b1, STAT_EMPTY, 5'd0},
      '{MODE_DEL_POS,  32'sd0,  8'd255, 1'b1, STAT_EMPTY, 5'd0},
      '{MODE_UNUSED5,  -32'sd1, 8'd255, 1'b1, STAT_DONE,  5'd0},
      // load the extremes
      '{MODE_APPEND,   WORD_MIN, 8'd0,   1'b1, STAT_DONE, 5'd1},
      '{MODE_APPEND,   WORD_MAX, 8'd255, 1'b1, STAT_DONE, 5'd2},
      '{MODE_APPEND,   -32'sd1,  8'd0,   1'b1, STAT_DONE, 5'd3},
      '{MODE_APPEND,   32'sd0,   8'd0,   1'b1, STAT_DONE, 5'd4},
      '{MODE_DISPLAY,  -32'sd1,  8'd255, 1'b0, STAT_DONE, 5'd0},
      // positions zero and past the tail are rejected
      '{MODE_DEL_POS,  32'sd0,  8'd0,   1'b1, STAT_RANGE, 5'd4},
      '{MODE_DEL_POS,  32'sd0,  8'd5,   1'b1, STAT_RANGE, 5'd4},
      '{MODE_DEL_POS,  32'sd0,  8'd255, 1'b1, STAT_RANGE, 5'd4},
      // delete the tail, the head, then a middle word by position
      '{MODE_DEL_POS,  32'sd0,  8'd4,   1'b1, STAT_DONE,  5'd3},
      '{MODE_DISPLAY,  32'sd0,  8'd0,   1'b0, STAT_DONE,  5'd0},
      '{MODE_DEL_POS,  32'sd0,  8'd1,   1'b1, STAT_DONE,  5'd2},
      '{MODE_UNUSED6,  WORD_MIN, 8'd1,  1'b1, STAT_DONE,  5'd2},
      '{MODE_UNUSED7,  WORD_MAX, 8'd2,  1'b1, STAT_DONE,  5'd2},
      '{MODE_APPEND,   32'sh5A5A_5A5A, 8'd0, 1'b1, STAT_DONE, 5'd3},
      '{MODE_DEL_POS,  32'sd0,  8'd2,   1'b1, STAT_DONE,  5'd2},
      '{MODE_DISPLAY,  32'sd0,  8'd0,   1'b0, STAT_DONE,  5'd0},
      '{MODE_DEL_HEAD, 32'sd0,  8'd0,   1'b1, STAT_DONE,  5'd1},
      '{MODE_DEL_TAIL, 32'sd0,  8'd0,   1'b1, STAT_DONE,  5'd0},
      '{MODE_DISPLAY,  32'sd0,  8'd0,   1'b1, STAT_EMPTY, 5'd0}
    };

    // Hold reset, then release it away from the rising edge.
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_ops[i])
      issue_op(directed_ops[i].mode, directed_ops[i].value, directed_ops[i].position,
               directed_ops[i].known_result, directed_ops[i].status, directed_ops[i].length);

    // Random sequences. Fill bursts run the list into full often; drain bursts
    // walk it back down so deletes and displays see every length.
    while (ops_sent < TOTAL_OPS) begin
      // Every third block of 40 transfers runs with no idling on either side.
      idle_on = ((ops_sent / 40) % 3) != 2;
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          burst = CAPACITY - list_len + $urandom_range(0, 2);
          repeat (burst) issue_op(MODE_APPEND, pick_word(), POS_W'($urandom_range(0, 255)));
        end
        3, 4: begin
          repeat ($urandom_range(1, 8)) begin
            pos_hi = (list_len > 0) ? list_len : 1;
            case ($urandom_range(0, 2))
              0:       issue_op(MODE_DEL_HEAD, pick_word(), POS_W'($urandom_range(0, 255)));
              1:       issue_op(MODE_DEL_TAIL, pick_word(), POS_W'($urandom_range(0, 255)));
              default: issue_op(MODE_DEL_POS, pick_word(), POS_W'($urandom_range(1, pos_hi)));
            endcase
          end
        end
        5, 6: issue_op(MODE_DISPLAY, pick_word(), POS_W'($urandom_range(0, 255)));
        7: begin
          // Position near the tail edge, or anywhere in the field.
          if ($urandom_range(0, 1))
            issue_op(MODE_DEL_POS, pick_word(), POS_W'($urandom_range(0, 255)));
          else
            issue_op(MODE_DEL_POS, pick_word(), POS_W'(list_len + $urandom_range(0, 2)));
        end
        8: issue_op(MODE_W'($urandom_range(MODE_UNUSED5, MODE_UNUSED7)), pick_word(),
                    POS_W'($urandom_range(0, 255)));
        default: issue_op(MODE_W'($urandom_range(0, 7)), $urandom,
                          POS_W'($urandom_range(0, 255)));
      endcase
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait out the last results, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
